// File: src/salpm_pkg.sv
// ----------------------------------------------------------------------------
// salpm_pkg
// shared constants and types for the suffix array prefix match unit
// ----------------------------------------------------------------------------
package salpm_pkg;

  localparam int TEXT_DEPTH = 4096;
  localparam int ADDR_W     = 12;
  localparam int LEN_W      = 13;
  localparam int QPOS_W     = 16;
  localparam int RES_W      = 17;
  localparam int POS_W      = 17;

  localparam logic [QPOS_W-1:0] QUERY_MAX = 16'hFFFF;

  localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(TEXT_DEPTH);

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

endpackage

// File: src/salpm_ram.sv
// ----------------------------------------------------------------------------
// salpm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module salpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/suffix_array_longest_prefix_match_unit.sv
// ----------------------------------------------------------------------------
// suffix_array_longest_prefix_match_unit
// streamed longest prefix match against an enhanced suffix array
// ----------------------------------------------------------------------------
// scan: the first character of a query scans the lcp rows in use, and each pass of
//   a narrowing step's loop scans the lcp rows of its range; both walk the rows
//   through the single lcp memory read port
// throughput: one request at a time; the result of a final character sits
//   in the output register while the next request is taken
// reset: rst_n synchronous active low clears control state and text_length;
//   the four tables are not cleared and must be loaded before use
module suffix_array_longest_prefix_match_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [salpm_pkg::LEN_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [salpm_pkg::ADDR_W-1:0]  in_entry_index,
  input  logic [7:0]                    in_text_byte,
  input  logic [salpm_pkg::ADDR_W-1:0]  in_suffix_start,
  input  logic [salpm_pkg::LEN_W-1:0]   in_lcp_value,
  input  logic [7:0]                    in_variant_byte,
  input  logic [7:0]                    in_query_byte,
  input  logic                          in_query_last,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [salpm_pkg::LEN_W-1:0] out_interval_low,
  output logic signed [salpm_pkg::LEN_W-1:0] out_interval_high,
  output logic signed [salpm_pkg::RES_W-1:0] out_match_length
);
  import salpm_pkg::*;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_RM_ISS, S_RM_RUN, S_STEP, S_SA_ISS, S_SA_DAT, S_TX_DAT,
    S_NV_ISS, S_NV_DAT, S_BRK, S_NI_ISS, S_NI_DAT, S_NL_ISS, S_NL_DAT, S_POST
  } state_t;

  // where a scan or a text fetch hands control back to
  typedef enum logic [1:0] {
    RET_INIT, RET_LOOP, RET_CHK, RET_OK
  } ret_t;

  localparam ret_t RET_FIN = RET_INIT;  // text fetch after commit reuses code

  state_t                state_r, state_nxt;
  logic [LEN_W-1:0]      text_length_r;
  logic [LEN_W-1:0]      cur_low_r, cur_low_nxt, cur_high_r, cur_high_nxt;
  logic [ADDR_W-1:0]     cur_split_r, cur_split_nxt;
  logic [RES_W-1:0]      cur_depth_r, cur_depth_nxt;
  logic [QPOS_W-1:0]     query_pos_r, query_pos_nxt;
  logic                  match_done_r, match_done_nxt;
  logic [RES_W-1:0]      result_length_r, result_length_nxt;
  logic [7:0]            qchar_r, qchar_nxt;
  logic                  qlast_r, qlast_nxt;
  // narrowing working set
  logic [LEN_W-1:0]      ni_r, ni_nxt, nj_r, nj_nxt;
  logic [ADDR_W-1:0]     nm_r, nm_nxt;
  // range-minimum scan unit
  logic [LEN_W-1:0]      rm_x_r, rm_x_nxt, rm_hi_r, rm_hi_nxt;
  logic [ADDR_W-1:0]     rm_best_r, rm_best_nxt;
  logic [LEN_W-1:0]      rm_bestv_r, rm_bestv_nxt;
  logic                  rm_first_r, rm_first_nxt;
  ret_t                  ret_r, ret_nxt;
  // text fetch unit
  logic [LEN_W-1:0]      tx_row_r, tx_row_nxt;
  logic [QPOS_W-1:0]     tx_off_r, tx_off_nxt;
  logic                  tx_inr_r, tx_inr_nxt;
  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [LEN_W-1:0]      out_low_r, out_low_nxt, out_high_r, out_high_nxt;
  logic [RES_W-1:0]      out_len_r, out_len_nxt;

  // memory ports
  logic                  load_we;
  logic [ADDR_W-1:0]     lcp_raddr, sa_raddr, txt_raddr, var_raddr;
  logic [LEN_W-1:0]      lcp_q;
  logic [ADDR_W-1:0]     sa_q;
  logic [7:0]            txt_q, var_q;

  logic [LEN_W-1:0]      eff_len;
  logic [POS_W-1:0]      tx_pos;
  logic [7:0]            tx_byte;
  logic                  rm_take, rm_end;
  logic [ADDR_W-1:0]     rm_best_c;
  logic [LEN_W-1:0]      rm_bestv_c;
  logic [LEN_W-1:0]      m_minus1;
  logic                  var_le;
  logic [RES_W-1:0]      k_ext;

  assign in_ready          = (state_r == S_IDLE);
  assign load_we           = in_valid && in_ready && (in_opcode == OP_LOAD);
  assign eff_len           = (text_length_r > DEPTH_LEN) ? DEPTH_LEN : text_length_r;
  assign tx_pos            = POS_W'(sa_q) + POS_W'(tx_off_r);
  assign tx_byte           = tx_inr_r ? txt_q : 8'd0;
  assign k_ext             = RES_W'(query_pos_r);
  assign m_minus1          = LEN_W'(nm_r) - LEN_W'(1);
  assign var_le            = $signed(var_q) <= $signed(qchar_r);

  // scan compare: leftmost minimum keeps the earlier row on ties
  assign rm_take    = rm_first_r || (lcp_q < rm_bestv_r);
  assign rm_best_c  = rm_take ? rm_x_r[ADDR_W-1:0] : rm_best_r;
  assign rm_bestv_c = rm_take ? lcp_q : rm_bestv_r;
  assign rm_end     = (rm_x_r >= rm_hi_r);

  // read address selection per state
  always_comb begin
    lcp_raddr = rm_x_r[ADDR_W-1:0];
    var_raddr = nm_r;
    if (state_r == S_RM_RUN) begin
      lcp_raddr = ADDR_W'(rm_x_r + LEN_W'(1));
    end else if (state_r == S_NL_ISS) begin
      lcp_raddr = nm_r;
    end
    if (state_r == S_NI_ISS) begin
      var_raddr = ni_r[ADDR_W-1:0];
    end
  end
  assign sa_raddr  = tx_row_r[ADDR_W-1:0];
  assign txt_raddr = tx_pos[ADDR_W-1:0];

  salpm_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_text_ram (
    .clk(clk), .we(load_we), .waddr(in_entry_index), .wdata(in_text_byte),
    .raddr(txt_raddr), .rdata(txt_q)
  );

  salpm_ram #(.WIDTH(ADDR_W), .DEPTH(TEXT_DEPTH)) u_sa_ram (
    .clk(clk), .we(load_we), .waddr(in_entry_index), .wdata(in_suffix_start),
    .raddr(sa_raddr), .rdata(sa_q)
  );

  salpm_ram #(.WIDTH(LEN_W), .DEPTH(TEXT_DEPTH)) u_lcp_ram (
    .clk(clk), .we(load_we), .waddr(in_entry_index), .wdata(in_lcp_value),
    .raddr(lcp_raddr), .rdata(lcp_q)
  );

  salpm_ram #(.WIDTH(8), .DEPTH(TEXT_DEPTH)) u_var_ram (
    .clk(clk), .we(load_we), .waddr(in_entry_index), .wdata(in_variant_byte),
    .raddr(var_raddr), .rdata(var_q)
  );

  // sequencer next state
  always_comb begin
    state_nxt         = state_r;
    cur_low_nxt       = cur_low_r;
    cur_high_nxt      = cur_high_r;
    cur_split_nxt     = cur_split_r;
    cur_depth_nxt     = cur_depth_r;
    query_pos_nxt     = query_pos_r;
    match_done_nxt    = match_done_r;
    result_length_nxt = result_length_r;
    qchar_nxt         = qchar_r;
    qlast_nxt         = qlast_r;
    ni_nxt            = ni_r;
    nj_nxt            = nj_r;
    nm_nxt            = nm_r;
    rm_x_nxt          = rm_x_r;
    rm_hi_nxt         = rm_hi_r;
    rm_best_nxt       = rm_best_r;
    rm_bestv_nxt      = rm_bestv_r;
    rm_first_nxt      = rm_first_r;
    ret_nxt           = ret_r;
    tx_row_nxt        = tx_row_r;
    tx_off_nxt        = tx_off_r;
    tx_inr_nxt        = tx_inr_r;
    out_low_nxt       = out_low_r;
    out_high_nxt      = out_high_r;
    out_len_nxt       = out_len_r;
    out_valid_nxt     = out_valid_r && !out_ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_opcode == OP_QUERY)) begin
          qchar_nxt = in_query_byte;
          qlast_nxt = in_query_last;
          state_nxt = S_STEP;
          if (query_pos_r == '0) begin
            // start of a query: whole table is the first interval
            match_done_nxt = 1'b0;
            cur_depth_nxt  = '0;
            cur_split_nxt  = '0;
            if (eff_len == '0) begin
              match_done_nxt    = 1'b1;
              cur_low_nxt       = '1;
              cur_high_nxt      = '1;
              result_length_nxt = '1;
            end else begin
              cur_low_nxt  = '0;
              cur_high_nxt = eff_len - LEN_W'(1);
              if (eff_len >= LEN_W'(2)) begin
                rm_x_nxt  = LEN_W'(1);
                rm_hi_nxt = eff_len - LEN_W'(1);
                ret_nxt   = RET_INIT;
                state_nxt = S_RM_ISS;
              end
            end
          end
        end
      end
      S_RM_ISS: begin
        rm_first_nxt = 1'b1;
        state_nxt    = S_RM_RUN;
      end
      S_RM_RUN: begin
        rm_first_nxt = 1'b0;
        rm_best_nxt  = rm_best_c;
        rm_bestv_nxt = rm_bestv_c;
        if (!rm_end) begin
          rm_x_nxt = rm_x_r + LEN_W'(1);
        end else if (ret_r == RET_INIT) begin
          cur_split_nxt = rm_best_c;
          state_nxt     = S_STEP;
        end else begin
          nm_nxt    = rm_best_c;
          state_nxt = (RES_W'(rm_bestv_c) != cur_depth_r) ? S_BRK : S_NV_ISS;
        end
      end
      S_STEP: begin
        if (match_done_r) begin
          state_nxt = S_POST;
        end else if ((cur_low_r == cur_high_r) || (k_ext < cur_depth_r)) begin
          tx_row_nxt = cur_low_r;
          tx_off_nxt = query_pos_r;
          ret_nxt    = RET_CHK;
          state_nxt  = S_SA_ISS;
        end else begin
          ni_nxt    = cur_low_r;
          nj_nxt    = cur_high_r;
          nm_nxt    = cur_split_r;
          state_nxt = S_NV_ISS;
        end
      end
      S_SA_ISS: begin
        state_nxt = S_SA_DAT;
      end
      S_SA_DAT: begin
        tx_inr_nxt = tx_pos < POS_W'(eff_len);
        state_nxt  = S_TX_DAT;
      end
      S_TX_DAT: begin
        state_nxt = S_POST;
        unique case (ret_r)
          RET_CHK: begin
            // a single-row text also stops at a zero byte
            if ((tx_byte != qchar_r) ||
                ((cur_low_r == cur_high_r) && (eff_len == LEN_W'(1)) &&
                 (tx_byte == 8'd0))) begin
              match_done_nxt    = 1'b1;
              result_length_nxt = k_ext;
            end
          end
          RET_OK: begin
            if (tx_byte != qchar_r) begin
              match_done_nxt    = 1'b1;
              result_length_nxt = k_ext;
            end else begin
              state_nxt = S_NL_ISS;
            end
          end
          default: begin
            if (tx_byte != qchar_r) begin
              match_done_nxt    = 1'b1;
              result_length_nxt = k_ext;
            end
          end
        endcase
      end
      S_NV_ISS: begin
        state_nxt = S_NV_DAT;
      end
      S_NV_DAT: begin
        if (var_le) begin
          ni_nxt = LEN_W'(nm_r);
        end else begin
          nj_nxt = m_minus1;
        end
        if ((var_le ? LEN_W'(nm_r) : ni_r) == (var_le ? nj_r : m_minus1)) begin
          state_nxt = S_BRK;
        end else begin
          rm_x_nxt  = (var_le ? LEN_W'(nm_r) : ni_r) + LEN_W'(1);
          rm_hi_nxt = var_le ? nj_r : m_minus1;
          ret_nxt   = RET_LOOP;
          state_nxt = S_RM_ISS;
        end
      end
      S_BRK: begin
        if (ni_r != cur_low_r) begin
          state_nxt = S_NI_ISS;
        end else begin
          tx_row_nxt = ni_r;
          tx_off_nxt = QPOS_W'(cur_depth_r);
          ret_nxt    = RET_OK;
          state_nxt  = S_SA_ISS;
        end
      end
      S_NI_ISS: begin
        state_nxt = S_NI_DAT;
      end
      S_NI_DAT: begin
        if (var_q != qchar_r) begin
          match_done_nxt    = 1'b1;
          result_length_nxt = k_ext;
          state_nxt         = S_POST;
        end else begin
          state_nxt = S_NL_ISS;
        end
      end
      S_NL_ISS: begin
        state_nxt = S_NL_DAT;
      end
      S_NL_DAT: begin
        // commit the narrowed interval, then confirm this character
        cur_low_nxt   = ni_r;
        cur_high_nxt  = nj_r;
        cur_split_nxt = nm_r;
        cur_depth_nxt = (RES_W'(lcp_q) > k_ext) ? RES_W'(lcp_q) : k_ext + RES_W'(1);
        tx_row_nxt    = ni_r;
        tx_off_nxt    = query_pos_r;
        ret_nxt       = RET_FIN;
        state_nxt     = S_SA_ISS;
      end
      S_POST: begin
        if (!qlast_r) begin
          query_pos_nxt = (query_pos_r < QUERY_MAX) ? query_pos_r + QPOS_W'(1) : QUERY_MAX;
          state_nxt     = S_IDLE;
        end else if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_low_nxt    = cur_low_r;
          out_high_nxt   = cur_high_r;
          out_len_nxt    = match_done_r ? result_length_r :
                           ((query_pos_r < QUERY_MAX) ? k_ext + RES_W'(1)
                                                      : RES_W'(QUERY_MAX));
          query_pos_nxt  = '0;
          match_done_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      text_length_r   <= '0;
      cur_low_r       <= '0;
      cur_high_r      <= '0;
      cur_split_r     <= '0;
      cur_depth_r     <= '0;
      query_pos_r     <= '0;
      match_done_r    <= 1'b0;
      result_length_r <= '0;
      out_valid_r     <= 1'b0;
      ret_r           <= RET_INIT;
      rm_first_r      <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      if (cfg_wr_en) begin
        text_length_r <= cfg_wr_data;
      end
      cur_low_r       <= cur_low_nxt;
      cur_high_r      <= cur_high_nxt;
      cur_split_r     <= cur_split_nxt;
      cur_depth_r     <= cur_depth_nxt;
      query_pos_r     <= query_pos_nxt;
      match_done_r    <= match_done_nxt;
      result_length_r <= result_length_nxt;
      out_valid_r     <= out_valid_nxt;
      ret_r           <= ret_nxt;
      rm_first_r      <= rm_first_nxt;
    end
    qchar_r    <= qchar_nxt;
    qlast_r    <= qlast_nxt;
    ni_r       <= ni_nxt;
    nj_r       <= nj_nxt;
    nm_r       <= nm_nxt;
    rm_x_r     <= rm_x_nxt;
    rm_hi_r    <= rm_hi_nxt;
    rm_best_r  <= rm_best_nxt;
    rm_bestv_r <= rm_bestv_nxt;
    tx_row_r   <= tx_row_nxt;
    tx_off_r   <= tx_off_nxt;
    tx_inr_r   <= tx_inr_nxt;
    out_low_r  <= out_low_nxt;
    out_high_r <= out_high_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_interval_low  = $signed(out_low_r);
  assign out_interval_high = $signed(out_high_r);
  assign out_match_length  = $signed(out_len_r);

  // a load request never leaves the sequencer busy
  a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == OP_LOAD)) |=> in_ready)
    else $error("load request did not return to idle");

  // a new result comes only from the post step of a final character
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r == S_POST) && $past(qlast_r)))
    else $error("result raised outside final character");

  // a fresh result leaves the query position cleared
  a_result_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ((query_pos_r == '0) && !match_done_r))
    else $error("query state not cleared after result");

  // the scan never runs past its upper row
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RM_RUN) |-> (rm_x_r <= rm_hi_r))
    else $error("range-minimum scan out of bounds");

endmodule
